// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the upscaler RTL. Each macro takes a
// label, the clock, the reset that disables the check, the property terms and
// the message. The bodies fall away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(name, clk, rst, expr, msg)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and codes of the pixel replicate upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

  // Field widths.
  localparam int PX_W    = 24;
  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 11;
  localparam int CFG_W   = 11;
  localparam int LEN_W   = 7;
  localparam int PAD_W   = 2;
  localparam int KIND_W  = 2;

  // Largest enlargement factor; bounded by the run length field.
  localparam logic [SCALE_W-1:0] MAX_SCALE = 7'd100;

  // Input item kinds carried in the input tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result kinds carried in the output tuser.
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // One accepted item on its way to the result stage.
  typedef struct packed {
    logic              reject;    // pixel arrived during replay
    logic              from_mem;  // pixel comes from the line store read
    logic              end_row;   // item completes an output scanline
    logic [PAD_W-1:0]  pad;       // padding bytes of the output row
    logic [LEN_W-1:0]  len;       // copies of the pixel
    logic [PX_W-1:0]   px;        // pixel taken from the input
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/pixel_replicate_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler for 24-bit scanlines with a line store
// that replays each source row for the vertical enlargement.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Content
//   s_*       in         tvalid / tready    tuser: op; tdata: blue, green, red
//   m_*       out        tvalid / tready    tuser: kind; tdata: pixel, run_length,
//                                           last; tlast: row_end
//   cfg_*     in         cfg_we             cfg_index selects, cfg_data is written
//
// One input item is taken per cycle unless the result stage stalls. A row end
// with padding yields two results and holds the input while the pad is sent.
// An accepted item is registered with its line store read, then passes the
// output register. Ticks while nothing is replayed take no result slot.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pixel_replicate_upscaler #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [pru_pkg::PX_W-1:0]     s_tdata,   // blue, green, red
  input  wire                          s_tuser,   // op
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [31:0]                  m_tdata,   // blue, green, red, run_length, last
  output logic [pru_pkg::KIND_W-1:0]   m_tuser,   // kind
  output logic                         m_tlast,   // row_end
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire  [pru_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW   = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int EW   = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CW   = ((EW > pru_pkg::WIDTH_W) ? EW : pru_pkg::WIDTH_W) + 1;

  // Configuration registers.
  logic [pru_pkg::SCALE_W-1:0] scale_factor;
  logic [pru_pkg::WIDTH_W-1:0] row_width;

  // Row state.
  logic [AW-1:0]               column_count;
  logic [AW-1:0]               replay_column;
  logic [pru_pkg::SCALE_W-1:0] rows_left;

  // Line store and its registered read port.
  logic [pru_pkg::PX_W-1:0]    line_store [MAX_ROW_PIXELS];
  logic [pru_pkg::PX_W-1:0]    rd_data;

  logic [pru_pkg::SCALE_W-1:0] eff_f;
  logic [CW-1:0]               rw_ext;
  logic [CW-1:0]               eff_w;
  logic [1:0]                  pad_prod;
  logic [pru_pkg::PAD_W-1:0]   pad;
  logic                        is_pix;
  logic                        busy;
  logic [AW-1:0]               sel_col;
  logic                        hit_end;
  logic                        in_acc;
  logic                        job_valid;
  pru_pkg::job_t               job;

  // Effective factor and width, clamped to the supported range.
  always_comb begin
    if (scale_factor == '0) begin
      eff_f = pru_pkg::SCALE_W'(1);
    end else if (scale_factor > pru_pkg::MAX_SCALE) begin
      eff_f = pru_pkg::MAX_SCALE;
    end else begin
      eff_f = scale_factor;
    end
    rw_ext = CW'(row_width);
    if (rw_ext == '0) begin
      eff_w = CW'(1);
    end else if (rw_ext > CW'(MAX_ROW_PIXELS)) begin
      eff_w = CW'(MAX_ROW_PIXELS);
    end else begin
      eff_w = rw_ext;
    end
  end

  // Output row padding depends only on the two low bits of width and factor.
  assign pad_prod = 2'(eff_w[1:0] * eff_f[1:0] * 2'd3);
  assign pad      = pru_pkg::PAD_W'(~pad_prod + 2'd1);

  // Decode of the offered item.
  assign is_pix  = (s_tuser == pru_pkg::OP_PIXEL);
  assign busy    = (rows_left != '0);
  assign sel_col = is_pix ? column_count : replay_column;
  assign hit_end = (CW'(sel_col) + CW'(1)) >= eff_w;
  assign in_acc  = s_tvalid && s_tready;

  // Every pixel and every tick during replay produces results.
  assign job_valid    = s_tvalid && (is_pix || busy);
  assign job.reject   = is_pix && busy;
  assign job.from_mem = !is_pix;
  assign job.end_row  = hit_end;
  assign job.pad      = pad;
  assign job.len      = eff_f;
  assign job.px       = s_tdata;

  // Configuration writes and row state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= pru_pkg::SCALE_W'(1);
      row_width     <= pru_pkg::WIDTH_W'(1);
      column_count  <= '0;
      replay_column <= '0;
      rows_left     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pru_pkg::REG_SCALE: scale_factor <= cfg_data[pru_pkg::SCALE_W-1:0];
          pru_pkg::REG_WIDTH: row_width    <= cfg_data[pru_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && is_pix && !busy) begin
        if (hit_end) begin
          column_count  <= '0;
          rows_left     <= eff_f - pru_pkg::SCALE_W'(1);
          replay_column <= '0;
        end else begin
          column_count  <= column_count + AW'(1);
        end
      end else if (in_acc && !is_pix && busy) begin
        if (hit_end) begin
          replay_column <= '0;
          rows_left     <= rows_left - pru_pkg::SCALE_W'(1);
        end else begin
          replay_column <= replay_column + AW'(1);
        end
      end
    end
  end

  // Line store: pixels write, ticks read. Both never fall in one cycle, and a
  // written entry is visible to a read in the very next cycle.
  always_ff @(posedge clk) begin
    if (in_acc && is_pix && !busy) begin
      line_store[column_count] <= s_tdata;
    end
    if (in_acc && !is_pix) begin
      rd_data <= line_store[replay_column];
    end
  end

  // Result stage and output register.
  pru_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (s_tready),
    .rd_data   (rd_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  `ASSERT_IMPLIES(a_replay_no_column, clk, rst, busy, column_count == '0, "source column advanced during replay")
  `ASSERT_IMPLIES(a_idle_replay_home, clk, rst, !busy, replay_column == '0, "replay column left off row start")
  `ASSERT_HOLDS(a_rows_bound, clk, rst, rows_left < pru_pkg::MAX_SCALE, "replay row count beyond the largest factor")

endmodule

`default_nettype wire

// ===== hdl/pru_emit.sv =====
// ----------------------------------------------------------------------------
// pru_emit
// Result stage: holds one item and sends its pixel run (or its reject result)
// and, at the end of a padded row, its padding run through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pru_emit (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         job_valid,
  input  wire pru_pkg::job_t          job,
  output logic                        job_ready,
  input  wire  [pru_pkg::PX_W-1:0]    rd_data,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [31:0]                 m_tdata,  // blue, green, red, run_length, last
  output logic [pru_pkg::KIND_W-1:0]  m_tuser,  // kind
  output logic                        m_tlast   // row_end
);

  logic          s1_valid;
  pru_pkg::job_t s1;
  logic          phase;

  logic                         two;
  logic                         out_free;
  logic                         final_res;
  logic [pru_pkg::KIND_W-1:0]   r_kind;
  logic [pru_pkg::PX_W-1:0]     r_px;
  logic [pru_pkg::LEN_W-1:0]    r_len;
  logic                         r_row_end;
  logic                         r_last;

  // A row end with padding yields a second result unless the item is rejected.
  assign two       = !s1.reject && s1.end_row && (s1.pad != '0);
  assign out_free  = !m_tvalid || m_tready;
  assign final_res = s1_valid && out_free && (phase || !two);
  assign job_ready = !s1_valid || final_res;

  // Select the result for the current phase.
  always_comb begin
    if (phase) begin
      r_kind    = pru_pkg::KIND_PAD;
      r_px      = '0;
      r_len     = pru_pkg::LEN_W'(s1.pad);
      r_row_end = 1'b1;
      r_last    = 1'b1;
    end else if (s1.reject) begin
      r_kind    = pru_pkg::KIND_REJECT;
      r_px      = '0;
      r_len     = '0;
      r_row_end = 1'b0;
      r_last    = 1'b1;
    end else begin
      r_kind    = pru_pkg::KIND_PIXEL;
      r_px      = s1.from_mem ? rd_data : s1.px;
      r_len     = s1.len;
      r_row_end = s1.end_row && !two;
      r_last    = !two;
    end
  end

  // Control of the held item, the phase and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
      if (s1_valid && out_free) begin
        phase <= !final_res;
      end
      if (job_ready) begin
        s1_valid <= job_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (job_ready) begin
      s1 <= job;
    end
    if (s1_valid && out_free) begin
      m_tdata <= {r_last, r_len, r_px};
      m_tuser <= r_kind;
      m_tlast <= r_row_end;
    end
  end

  `ASSERT_IMPLIES(a_phase_needs_item, clk, rst, phase, s1_valid && two, "second phase without a padded row end")
  `ASSERT_IMPLIES(a_pad_ends_row, clk, rst, m_tvalid && (m_tuser == pru_pkg::KIND_PAD), m_tlast && m_tdata[31], "padding run does not close the row")
  `ASSERT_NEXT(a_item_held, clk, rst, s1_valid && !job_ready, s1_valid && $stable(s1), "held item changed while stalled")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel replicate upscaler. A cycle-free software
// copy of the upscaler predicts every result run of each accepted transaction.
// A monitor on the output stream compares each result with the oldest
// prediction. Stimulus covers directed corners and then randomized rows under
// random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_SLACK    = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_MAX     = 10;

  // One result run as seen on the output stream.
  typedef struct packed {
    logic [pru_pkg::KIND_W-1:0] kind;
    logic [7:0]                 blue;
    logic [7:0]                 green;
    logic [7:0]                 red;
    logic [pru_pkg::LEN_W-1:0]  run_len;
    logic                       row_end;
    logic                       last;
  } run_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [pru_pkg::PX_W-1:0]     s_tdata;   // blue, green, red
  logic                         s_tuser;   // op
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [31:0]                  m_tdata;   // blue, green, red, run_length, last
  logic [pru_pkg::KIND_W-1:0]   m_tuser;   // kind
  logic                         m_tlast;   // row_end
  logic                         cfg_we;
  logic                         cfg_index;
  logic [pru_pkg::CFG_W-1:0]    cfg_data;

  // Shared bench controls.
  bit          no_idle = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned error_count = 0;
  int unsigned report_count = 0;
  int unsigned cycle_count = 0;

  // Predicted runs still waiting for their output transaction.
  run_t pending_runs[$];

  // Software copy of the upscaler state and registers.
  logic [pru_pkg::SCALE_W-1:0] scale_reg;
  logic [pru_pkg::WIDTH_W-1:0] width_reg;
  logic [pru_pkg::PX_W-1:0]    line_mem [MAX_ROW_PIXELS];
  int unsigned                 col_count;
  int unsigned                 rows_left;
  int unsigned                 replay_col;
  int unsigned                 filled_entries;

  pixel_replicate_upscaler #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Effective factor: zero counts as one, large values stop at the maximum.
  function automatic int unsigned clamp_scale(int unsigned v);
    if (v == 0) return 1;
    if (v > 32'(pru_pkg::MAX_SCALE)) return 32'(pru_pkg::MAX_SCALE);
    return v;
  endfunction

  // Effective row width: zero counts as one, large values stop at the buffer size.
  function automatic int unsigned clamp_width(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return v;
  endfunction

  function automatic run_t make_run(logic [pru_pkg::KIND_W-1:0] kind,
                                    logic [pru_pkg::PX_W-1:0] px,
                                    int unsigned len, logic row_end, logic last);
    run_t r;
    r.kind    = kind;
    r.blue    = px[7:0];
    r.green   = px[15:8];
    r.red     = px[23:16];
    r.run_len = pru_pkg::LEN_W'(len);
    r.row_end = row_end;
    r.last    = last;
    return r;
  endfunction

  // Queue the pixel run and, at a row end, the padding run the output row needs.
  function automatic void queue_pixel_run(logic [pru_pkg::PX_W-1:0] px, bit at_row_end);
    int unsigned f;
    int unsigned pad;
    f = clamp_scale(scale_reg);
    if (!at_row_end) begin
      pending_runs.push_back(make_run(pru_pkg::KIND_PIXEL, px, f, 1'b0, 1'b1));
      return;
    end
    pad = (4 - ((clamp_width(width_reg) * f * 3) & 3)) & 3;
    if (pad == 0) begin
      pending_runs.push_back(make_run(pru_pkg::KIND_PIXEL, px, f, 1'b1, 1'b1));
    end else begin
      pending_runs.push_back(make_run(pru_pkg::KIND_PIXEL, px, f, 1'b0, 1'b0));
      pending_runs.push_back(make_run(pru_pkg::KIND_PAD, '0, pad, 1'b1, 1'b1));
    end
  endfunction

  // Advance the software copy by one accepted input transaction.
  function automatic void upscale_step(logic op, logic [pru_pkg::PX_W-1:0] px);
    int unsigned w;
    int unsigned col;
    bit at_end;
    w = clamp_width(width_reg);
    if (op == pru_pkg::OP_PIXEL) begin
      if (rows_left != 0) begin
        pending_runs.push_back(make_run(pru_pkg::KIND_REJECT, '0, 0, 1'b0, 1'b1));
        return;
      end
      col = col_count;
      line_mem[col] = px;
      if (col + 1 > filled_entries) filled_entries = col + 1;
      at_end = (col + 1 >= w);
      if (at_end) begin
        col_count  = 0;
        rows_left  = clamp_scale(scale_reg) - 1;
        replay_col = 0;
      end else begin
        col_count = col + 1;
      end
      queue_pixel_run(px, at_end);
    end else begin
      if (rows_left == 0) return;
      col = replay_col;
      at_end = (col + 1 >= w);
      if (at_end) begin
        replay_col = 0;
        rows_left  = rows_left - 1;
      end else begin
        replay_col = col + 1;
      end
      queue_pixel_run(line_mem[col], at_end);
    end
  endfunction

  // Offer one input transaction, with random idle cycles ahead of it.
  task automatic send_item(input logic op, input logic [pru_pkg::PX_W-1:0] px);
    while (!no_idle && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    upscale_step(op, px);
  endtask

  // Write a register once the block has gone quiet.
  task automatic write_reg(input logic idx, input logic [pru_pkg::CFG_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pru_pkg::REG_SCALE) scale_reg = val[pru_pkg::SCALE_W-1:0];
    else width_reg = val[pru_pkg::WIDTH_W-1:0];
  endtask

  // Send ticks until the stored row has been replayed completely.
  task automatic finish_replay();
    while (rows_left != 0) send_item(pru_pkg::OP_TICK, pru_pkg::PX_W'($urandom));
  endtask

  // Mostly well-formed rows and replays, with stray ticks and pixels
  // arriving during replay mixed in. Ignored ticks are not counted.
  task automatic run_traffic(input int unsigned n, inout int unsigned total);
    int unsigned sent;
    logic op;
    sent = 0;
    while (sent < n) begin
      if (rows_left != 0) begin
        op = ($urandom_range(99) < 6) ? pru_pkg::OP_PIXEL : pru_pkg::OP_TICK;
      end else begin
        op = ($urandom_range(99) < 4) ? pru_pkg::OP_TICK : pru_pkg::OP_PIXEL;
      end
      if (!(op == pru_pkg::OP_TICK && rows_left == 0)) sent++;
      send_item(op, pru_pkg::PX_W'($urandom));
    end
    total += sent;
  endtask

  // Reset values: one by one with padding, and a tick that finds nothing.
  task automatic test_reset_values();
    send_item(pru_pkg::OP_TICK, 24'hFFFFFF);
    send_item(pru_pkg::OP_PIXEL, 24'hFFFFFF);
    send_item(pru_pkg::OP_PIXEL, 24'h000000);
    send_item(pru_pkg::OP_PIXEL, 24'h5AA5C3);
  endtask

  // Zero in both registers behaves as one.
  task automatic test_zero_registers();
    write_reg(pru_pkg::REG_SCALE, '0);
    write_reg(pru_pkg::REG_WIDTH, '0);
    send_item(pru_pkg::OP_PIXEL, 24'h123456);
    send_item(pru_pkg::OP_TICK, 24'hABCDEF);
  endtask

  // A two-pixel row at factor three: padding, replay and a rejected pixel.
  task automatic test_row_replay();
    write_reg(pru_pkg::REG_SCALE, 11'd3);
    write_reg(pru_pkg::REG_WIDTH, 11'd2);
    send_item(pru_pkg::OP_PIXEL, 24'hFF0080);
    send_item(pru_pkg::OP_PIXEL, 24'h01FE7F);
    send_item(pru_pkg::OP_PIXEL, 24'hFFFFFF);
    finish_replay();
    send_item(pru_pkg::OP_TICK, 24'h000000);
  endtask

  // Width lowered mid-row, then both registers changed during replay.
  task automatic test_midstream_changes();
    write_reg(pru_pkg::REG_SCALE, 11'd2);
    write_reg(pru_pkg::REG_WIDTH, 11'd4);
    send_item(pru_pkg::OP_PIXEL, 24'h102030);
    send_item(pru_pkg::OP_PIXEL, 24'h405060);
    write_reg(pru_pkg::REG_WIDTH, 11'd2);
    send_item(pru_pkg::OP_PIXEL, 24'h708090);
    write_reg(pru_pkg::REG_SCALE, 11'd3);
    send_item(pru_pkg::OP_TICK, 24'h0);
    write_reg(pru_pkg::REG_WIDTH, 11'd1);
    finish_replay();
  endtask

  // Factor above the maximum saturates; the replay runs the full count.
  task automatic test_scale_limits();
    write_reg(pru_pkg::REG_SCALE, 11'd127);
    write_reg(pru_pkg::REG_WIDTH, 11'd1);
    send_item(pru_pkg::OP_PIXEL, 24'hC0FFEE);
    send_item(pru_pkg::OP_PIXEL, 24'h0F0F0F);
    finish_replay();
  endtask

  // Width above the buffer size saturates to one full buffer.
  task automatic test_widest_row();
    write_reg(pru_pkg::REG_SCALE, 11'd1);
    write_reg(pru_pkg::REG_WIDTH, 11'h7FF);
    for (int i = 0; i < MAX_ROW_PIXELS; i++) begin
      send_item(pru_pkg::OP_PIXEL, pru_pkg::PX_W'($urandom));
    end
  endtask

  // The receiver stalls for a long time while the sender keeps offering.
  task automatic test_output_backpressure();
    int unsigned total;
    total = 0;
    write_reg(pru_pkg::REG_SCALE, 11'd3);
    write_reg(pru_pkg::REG_WIDTH, 11'd4);
    hold_requests++;
    run_traffic(60, total);
  endtask

  // Phases of random traffic, each under a freshly drawn register setting.
  task automatic test_random_stream(input int unsigned target);
    int unsigned total;
    int unsigned phase;
    int unsigned pick;
    int unsigned s;
    int unsigned w;
    total = 0;
    phase = 0;
    while (total < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        s = $urandom_range(4, 1);
        w = $urandom_range(9, 1);
      end else if (pick < 80) begin
        s = $urandom_range(12, 5);
        w = $urandom_range(4, 1);
      end else if (pick < 86) begin
        s = 0;
        w = $urandom_range(12, 0);
      end else if (pick < 92) begin
        s = $urandom_range(127, 100);
        w = $urandom_range(2, 1);
      end else begin
        s = $urandom_range(3, 1);
        w = $urandom_range(60, 20);
      end
      // A replay must never reach entries that were never written.
      if (rows_left != 0 && clamp_width(w) > filled_entries) w = filled_entries;
      write_reg(pru_pkg::REG_SCALE, pru_pkg::CFG_W'(s));
      write_reg(pru_pkg::REG_WIDTH, pru_pkg::CFG_W'(w));
      no_idle = (phase >= 2 && phase < 4);
      run_traffic($urandom_range(120, 40), total);
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // Output monitor and receiver: checks each transaction, idles at random and
  // serves requested long stalls.
  task automatic check_result();
    run_t got;
    run_t want;
    got.kind    = m_tuser;
    got.blue    = m_tdata[7:0];
    got.green   = m_tdata[15:8];
    got.red     = m_tdata[23:16];
    got.run_len = m_tdata[30:24];
    got.last    = m_tdata[31];
    got.row_end = m_tlast;
    if (pending_runs.size() == 0) begin
      error_count++;
      if (report_count < REPORT_MAX) begin
        report_count++;
        $display("Unexpected result: kind=%0d bgr=%02h %02h %02h len=%0d row_end=%0b last=%0b",
                 got.kind, got.blue, got.green, got.red, got.run_len, got.row_end, got.last);
      end
      return;
    end
    want = pending_runs.pop_front();
    if (got !== want) begin
      error_count++;
      if (report_count < REPORT_MAX) begin
        report_count++;
        $display("Mismatch: expected kind=%0d bgr=%02h %02h %02h len=%0d row_end=%0b last=%0b",
                 want.kind, want.blue, want.green, want.red, want.run_len, want.row_end,
                 want.last);
        $display("          actual   kind=%0d bgr=%02h %02h %02h len=%0d row_end=%0b last=%0b",
                 got.kind, got.blue, got.green, got.red, got.run_len, got.row_end, got.last);
      end
    end
  endtask

  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL pixel_replicate_upscaler");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= pru_pkg::OP_PIXEL;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= pru_pkg::REG_SCALE;
    cfg_data  <= '0;
    scale_reg = pru_pkg::SCALE_W'(1);
    width_reg = pru_pkg::WIDTH_W'(1);
    col_count = 0;
    rows_left = 0;
    replay_col = 0;
    filled_entries = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_zero_registers();
    test_row_replay();
    test_midstream_changes();
    test_scale_limits();
    test_widest_row();
    test_output_backpressure();
    // The directed tests above already send about 1200 transactions.
    test_random_stream(520);

    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_runs.size() == 0) begin
      $display("PASS pixel_replicate_upscaler");
    end else begin
      $display("FAIL pixel_replicate_upscaler");
    end
    $finish;
  end

endmodule
